### design/mcfc_pkg.sv
// Shared types, frame constants and CRC-8 helpers for the monitor chain frame codec.
// No dependencies; mcfc_front, mcfc_mid, mcfc_back and the top module import this package.
package mcfc_pkg;

  // Command codes
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Frame layout constants
  localparam logic [2:0] FRAME_TAIL = 3'b010;

  // Payload carried between pipeline stages
  typedef struct packed {
    logic        cmd;
    logic [31:0] word;  // write frame with CRC/tail zero, or the received frame
    logic [4:0]  addr;  // bit-reversed device index
    logic [7:0]  crc;   // running CRC over the leading bits of word
  } stage_t;

  // One result beat
  typedef struct packed {
    logic [31:0] frame_out;
    logic        crc_ok;
    logic [11:0] conversion_value;
    logic [5:0]  address_field;
    logic        address_match;
  } result_t;

  // One MSB-first CRC step, x^8+x^5+x^3+x^2+x+1
  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic d);
    logic c7;
    c7 = c[7];
    return {c[6], c[5], c[4] ^ c7, c[3], c[2] ^ c7, c[1] ^ c7, c[0] ^ c7, d ^ c7};
  endfunction

  // Eight CRC steps over a byte, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = crc_step(r, b[7-i]);
    end
    return r;
  endfunction

endpackage

### design/mcfc_in_if.sv
// Input channel of the monitor chain frame codec: valid/ready plus command payload.
// Depends on nothing.
interface mcfc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [4:0]  device_index;
  logic [5:0]  register_addr;
  logic [7:0]  reg_data;
  logic        to_all;
  logic [31:0] read_frame;

  modport source(output valid, cmd, device_index, register_addr, reg_data, to_all,
                 read_frame, input ready);
  modport sink(input valid, cmd, device_index, register_addr, reg_data, to_all,
               read_frame, output ready);
endinterface

### design/mcfc_out_if.sv
// Output channel of the monitor chain frame codec: valid/ready plus result payload.
// Depends on nothing.
interface mcfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_out;
  logic        crc_ok;
  logic [11:0] conversion_value;
  logic [5:0]  address_field;
  logic        address_match;

  modport source(output valid, frame_out, crc_ok, conversion_value, address_field,
                 address_match, input ready);
  modport sink(input valid, frame_out, crc_ok, conversion_value, address_field,
               address_match, output ready);
endinterface

### design/mcfc_front.sv
// First pipeline stage: selects the frame word and runs the CRC over bits 31:24.
// Depends on mcfc_pkg and mcfc_in_if.
module mcfc_front
  import mcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mcfc_in_if.sink    in_ch,
  output logic       out_valid,
  output stage_t     out_data,
  input  logic       down_ready
);

  logic   [4:0] rev;
  stage_t       stage_next;

  // Reverse the index and assemble the word to protect
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      rev[4-i] = in_ch.device_index[i];
    end
    stage_next.cmd  = in_ch.cmd;
    stage_next.addr = rev;
    if (in_ch.cmd == CMD_CHECK) begin
      stage_next.word = in_ch.read_frame;
    end else begin
      stage_next.word = {rev, in_ch.register_addr, in_ch.reg_data, in_ch.to_all, 12'd0};
    end
    stage_next.crc = crc_byte(8'h00, stage_next.word[31:24]);
  end

  // Advance when empty or when the next stage takes the beat
  assign in_ch.ready = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### design/mcfc_mid.sv
// Second pipeline stage: continues the CRC over bits 23:16 of the frame word.
// Depends on mcfc_pkg.
module mcfc_mid
  import mcfc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   in_ready,
  output logic   out_valid,
  output stage_t out_data,
  input  logic   down_ready
);

  stage_t stage_next;

  // Fold in the second byte
  always_comb begin
    stage_next     = in_data;
    stage_next.crc = crc_byte(in_data.crc, in_data.word[23:16]);
  end

  assign in_ready = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### design/mcfc_back.sv
// Last pipeline stage: finishes the CRC, forms the result and holds the output register.
// Depends on mcfc_pkg and mcfc_out_if.
module mcfc_back
  import mcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  stage_t     in_data,
  output logic       in_ready,
  mcfc_out_if.source out_ch
);

  logic    [7:0] crc;
  result_t       res_next;
  result_t       res;
  logic          valid;

  // Finish the CRC: bits 15:11 always, bit 10 only when checking
  always_comb begin
    crc = in_data.crc;
    for (int i = 0; i < 5; i++) begin
      crc = crc_step(crc, in_data.word[15-i]);
    end
    if (in_data.cmd == CMD_CHECK) begin
      crc = crc_step(crc, in_data.word[10]);
    end
  end

  // Form the result fields; the unused side reads as zero
  always_comb begin
    res_next = '0;
    if (in_data.cmd == CMD_CHECK) begin
      res_next.crc_ok           = (in_data.word != 32'd0) && (in_data.word[9:2] == crc);
      res_next.conversion_value = in_data.word[22:11];
      res_next.address_field    = in_data.word[31:26];
      res_next.address_match    = (in_data.word[31:26] == {1'b0, in_data.addr});
    end else begin
      res_next.frame_out = {in_data.word[31:11], crc, FRAME_TAIL};
    end
  end

  // Output register parts the pipeline from the sink
  assign in_ready = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
    end
  end

  assign out_ch.valid            = valid;
  assign out_ch.frame_out        = res.frame_out;
  assign out_ch.crc_ok           = res.crc_ok;
  assign out_ch.conversion_value = res.conversion_value;
  assign out_ch.address_field    = res.address_field;
  assign out_ch.address_match    = res.address_match;

`ifndef SYNTHESIS
  // A build beat carries the tail; a check beat has an all-zero frame
  a_tail: assert property (@(posedge clk) disable iff (rst)
    valid |-> (res.frame_out[2:0] == FRAME_TAIL) || (res.frame_out == 32'd0))
    else $error("frame_out neither a tailed write frame nor zero");

  // A build beat leaves every read field zero
  a_build_clean: assert property (@(posedge clk) disable iff (rst)
    valid && (res.frame_out != 32'd0) |->
      !res.crc_ok && !res.address_match && (res.conversion_value == 12'd0) &&
      (res.address_field == 6'd0))
    else $error("build beat carries read fields");

  // The reversed index is five bits, so a match needs a clear top address bit
  a_match_msb: assert property (@(posedge clk) disable iff (rst)
    valid && res.address_match |-> !res.address_field[5])
    else $error("address match with address bit 5 set");

  // A stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ch.ready |=> valid && $stable(res))
    else $error("stalled result beat changed");
`endif

endmodule

### design/monitor_chain_frame_codec_top.sv
// Path: an accepted input beat passes the front, mid and back registers before its result beat shows on out_ch.
// Throughput: one beat per cycle while out_ch is ready; three CRC stages each fold up to eight frame bits.
// Each stage has its own valid bit and takes a beat when empty or when draining.
// Reset (rst, synchronous, active high) clears all stage valid bits; no other state.
// Depends on mcfc_pkg, mcfc_in_if, mcfc_out_if, mcfc_front, mcfc_mid, mcfc_back.
module monitor_chain_frame_codec_top
  import mcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mcfc_in_if.sink    in_ch,
  mcfc_out_if.source out_ch
);

  logic   s1_valid;
  logic   s1_ready;
  stage_t s1_data;
  logic   s2_valid;
  logic   s2_ready;
  stage_t s2_data;

  // Assemble the word and fold the leading byte
  mcfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_valid  (s1_valid),
    .out_data   (s1_data),
    .down_ready (s1_ready)
  );

  // Fold the second byte
  mcfc_mid u_mid (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .in_data    (s1_data),
    .in_ready   (s1_ready),
    .out_valid  (s2_valid),
    .out_data   (s2_data),
    .down_ready (s2_ready)
  );

  // Finish the CRC and register the result
  mcfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_data  (s2_data),
    .in_ready (s2_ready),
    .out_ch   (out_ch)
  );

endmodule

### verif/tb_monitor_chain_frame_codec_top.sv
// Self-checking testbench for monitor_chain_frame_codec_top: write-frame build and read-frame check.
// Depends on mcfc_pkg, mcfc_in_if, mcfc_out_if and the codec RTL.
`timescale 1ns / 100ps

module tb_monitor_chain_frame_codec_top;
  import mcfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNKS      = 7;
  localparam int CHUNK_ITEMS = 250;
  localparam int HOLD_AT     = 600;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 400;
  localparam logic [7:0] CRC_POLY = 8'h2F;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  device_index;
    logic [5:0]  register_addr;
    logic [7:0]  reg_data;
    logic        to_all;
    logic [31:0] read_frame;
  } codec_req_t;

  logic clk;
  logic rst;

  mcfc_in_if  in_ch();
  mcfc_out_if out_ch();

  monitor_chain_frame_codec_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  codec_req_t queued_cmds[$];
  result_t    pending_results[$];
  int         mismatches   = 0;
  int         results_seen = 0;
  int         cycle_count  = 0;
  bit         beat_taken   = 0;
  int         src_gap      = 0;
  int         sink_gap     = 0;
  int         hold_left    = 0;
  bit         hold_done    = 0;

  // Serial CRC-8, MSB first over the top nbits of word, zero start
  function automatic logic [7:0] chain_crc8(logic [31:0] word, int nbits);
    logic [7:0] c;
    logic       fb;
    c = 8'h00;
    for (int i = 0; i < nbits; i++) begin
      fb = c[7];
      c  = {c[6:0], word[31-i]} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [4:0] mirror5(logic [4:0] x);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) r[4-i] = x[i];
    return r;
  endfunction

  // Put the correct CRC into bits 9:2 of a read frame
  function automatic logic [31:0] seal_frame(logic [31:0] w);
    w[9:2] = chain_crc8(w, 22);
    return w;
  endfunction

  // Expected result beat for one command beat
  function automatic result_t codec_predict(codec_req_t r);
    result_t    res;
    logic [4:0] dev_addr;
    logic [31:0] f;
    res      = '0;
    dev_addr = mirror5(r.device_index);
    if (r.cmd == CMD_BUILD) begin
      f       = {dev_addr, r.register_addr, r.reg_data, r.to_all, 12'h000};
      f[10:3] = chain_crc8(f, 21);
      f[2:0]  = FRAME_TAIL;
      res.frame_out = f;
    end else begin
      res.crc_ok           = (r.read_frame != 32'h0) &&
                             (r.read_frame[9:2] == chain_crc8(r.read_frame, 22));
      res.conversion_value = r.read_frame[22:11];
      res.address_field    = r.read_frame[31:26];
      res.address_match    = (r.read_frame[31:26] == {1'b0, dev_addr});
    end
    return res;
  endfunction

  function automatic codec_req_t make_build(logic [4:0] idx, logic [5:0] ra, logic [7:0] d,
                                            logic all);
    codec_req_t r;
    r.cmd           = CMD_BUILD;
    r.device_index  = idx;
    r.register_addr = ra;
    r.reg_data      = d;
    r.to_all        = all;
    r.read_frame    = $urandom;
    return r;
  endfunction

  function automatic codec_req_t make_check(logic [31:0] frame, logic [4:0] idx);
    codec_req_t r;
    r.cmd           = CMD_CHECK;
    r.device_index  = idx;
    r.register_addr = 6'($urandom);
    r.reg_data      = 8'($urandom);
    r.to_all        = 1'($urandom);
    r.read_frame    = frame;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none at all in calm stretches
  function automatic int pick_gap(bit calm);
    int sel;
    if (calm) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got 0x%08h, want 0x%08h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Block until nothing is queued, offered or outstanding
  task automatic drain_wait();
    while (queued_cmds.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Clock and reset
  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_BUILD;
    in_ch.device_index  = '0;
    in_ch.register_addr = '0;
    in_ch.reg_data      = '0;
    in_ch.to_all        = 1'b0;
    in_ch.read_frame    = '0;
    out_ch.ready        = 1'b0;
    fork
      forever #6 clk = ~clk;
      begin
        repeat (2) @(posedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  // Drive command beats at the falling edge
  always @(negedge clk) begin
    codec_req_t r;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !beat_taken) begin
      // hold the offered beat
    end else if (src_gap > 0) begin
      src_gap--;
      in_ch.valid <= 1'b0;
    end else if (queued_cmds.size() > 0) begin
      r = queued_cmds.pop_front();
      in_ch.cmd           <= r.cmd;
      in_ch.device_index  <= r.device_index;
      in_ch.register_addr <= r.register_addr;
      in_ch.reg_data      <= r.reg_data;
      in_ch.to_all        <= r.to_all;
      in_ch.read_frame    <= r.read_frame;
      in_ch.valid         <= 1'b1;
      src_gap = pick_gap(cycle_count[9:8] == 2'b11);
    end else begin
      in_ch.valid <= 1'b0;
    end
    beat_taken = 1'b0;
  end

  // Receiver ready, with one long hold-off counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      sink_gap = pick_gap(cycle_count[10:9] == 2'b01);
    end
  end

  // Record accepted beats and check result beats at the rising edge
  always @(posedge clk) begin
    codec_req_t r;
    result_t    got;
    result_t    want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end else if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        r.cmd           = in_ch.cmd;
        r.device_index  = in_ch.device_index;
        r.register_addr = in_ch.register_addr;
        r.reg_data      = in_ch.reg_data;
        r.to_all        = in_ch.to_all;
        r.read_frame    = in_ch.read_frame;
        pending_results.push_back(codec_predict(r));
        beat_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.frame_out        = out_ch.frame_out;
        got.crc_ok           = out_ch.crc_ok;
        got.conversion_value = out_ch.conversion_value;
        got.address_field    = out_ch.address_field;
        got.address_match    = out_ch.address_match;
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing expected", got.frame_out, 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (got.frame_out !== want.frame_out)
            flag_mismatch("frame_out", got.frame_out, want.frame_out);
          if (got.crc_ok !== want.crc_ok)
            flag_mismatch("crc_ok", 32'(got.crc_ok), 32'(want.crc_ok));
          if (got.conversion_value !== want.conversion_value)
            flag_mismatch("conversion_value", 32'(got.conversion_value),
                          32'(want.conversion_value));
          if (got.address_field !== want.address_field)
            flag_mismatch("address_field", 32'(got.address_field), 32'(want.address_field));
          if (got.address_match !== want.address_match)
            flag_mismatch("address_match", 32'(got.address_match), 32'(want.address_match));
        end
        results_seen++;
      end
    end
  end

  // Stimulus: directed beats, then random chunks with a full drain between them
  initial begin
    codec_req_t  r;
    logic [31:0] w;
    int          sel;

    // extremes of the build fields and the address reversal
    queued_cmds.push_back(make_build(5'd0, 6'd0, 8'd0, 1'b0));
    queued_cmds.push_back(make_build(5'd31, 6'd63, 8'd255, 1'b1));
    queued_cmds.push_back(make_build(5'd1, 6'd0, 8'd0, 1'b0));
    queued_cmds.push_back(make_build(5'd16, 6'd1, 8'd128, 1'b0));
    queued_cmds.push_back(make_build(5'b10101, 6'h2A, 8'h55, 1'b0));
    queued_cmds.push_back(make_build(5'b01010, 6'h15, 8'hAA, 1'b1));
    r = make_build(5'd3, 6'd9, 8'h3C, 1'b1);
    r.read_frame = 32'hFFFF_FFFF;
    queued_cmds.push_back(r);

    // all-zero frame is rejected even though its CRC field matches
    queued_cmds.push_back(make_check(32'h0000_0000, 5'd0));
    queued_cmds.push_back(make_check(32'h0000_0003, 5'd0));
    queued_cmds.push_back(make_check(32'hFFFF_FFFF, 5'd31));
    queued_cmds.push_back(make_check(seal_frame(32'h007F_F800), 5'd0));
    // address field with top bit clear matches, with top bit set never does
    w = $urandom;
    w[31:26] = {1'b0, mirror5(5'd6)};
    queued_cmds.push_back(make_check(seal_frame(w), 5'd6));
    w[31:26] = {1'b1, mirror5(5'd6)};
    queued_cmds.push_back(make_check(seal_frame(w), 5'd6));
    w[31:26] = {1'b0, mirror5(5'd31)};
    queued_cmds.push_back(make_check(seal_frame(w), 5'd31));
    // bad CRC still extracts the fields
    queued_cmds.push_back(make_check(seal_frame(w) ^ 32'h0000_0004, 5'd31));
    queued_cmds.push_back(make_check(seal_frame(w) ^ 32'h0000_0800, 5'd31));
    queued_cmds.push_back(make_check(seal_frame(w) ^ 32'h8000_0000, 5'd31));
    r = make_check(seal_frame(32'h1234_5678), 5'd31);
    r.register_addr = 6'd63;
    r.reg_data      = 8'd255;
    r.to_all        = 1'b1;
    queued_cmds.push_back(r);
    drain_wait();

    for (int c = 0; c < CHUNKS; c++) begin
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        r.cmd           = 1'($urandom_range(0, 1));
        r.device_index  = 5'($urandom);
        r.register_addr = 6'($urandom);
        r.reg_data      = 8'($urandom);
        r.to_all        = 1'($urandom);
        r.read_frame    = $urandom;
        if (r.cmd == CMD_CHECK) begin
          w = $urandom;
          if ($urandom_range(0, 3) == 0) w[31:26] = {1'b0, mirror5(r.device_index)};
          sel = $urandom_range(0, 99);
          // mostly well-formed frames, some with one corrupted bit, some noise
          if (sel < 60)
            r.read_frame = seal_frame(w);
          else if (sel < 80)
            r.read_frame = seal_frame(w) ^ (32'h1 << $urandom_range(2, 31));
          else
            r.read_frame = w;
        end
        queued_cmds.push_back(r);
      end
      drain_wait();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### monitor_chain_frame_codec_top.f
design/mcfc_pkg.sv
design/mcfc_in_if.sv
design/mcfc_out_if.sv
design/mcfc_front.sv
design/mcfc_mid.sv
design/mcfc_back.sv
design/monitor_chain_frame_codec_top.sv
verif/tb_monitor_chain_frame_codec_top.sv
